>>> hdl/block_range_minimum_core_assert.svh
// Assertion macros for the range minimum core.
`ifndef BLOCK_RANGE_MINIMUM_CORE_ASSERT_SVH
`define BLOCK_RANGE_MINIMUM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Plain property, checked at every rising edge outside reset.
`define BRM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("block_range_minimum_core: property failed");
// Overlapping implication, checked at every rising edge outside reset.
`define BRM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("block_range_minimum_core: implication failed");
`else
`define BRM_ASSERT(label, clk, rst, prop)
`define BRM_ASSERT_IMP(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/brm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and control structs of the range minimum core.
package brm_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int BLOCK_SIZE   = 32;
   localparam int NUM_BLOCKS   = MAX_ELEMENTS / BLOCK_SIZE;
   localparam int POS_W        = $clog2(MAX_ELEMENTS);
   localparam int OFF_W        = $clog2(BLOCK_SIZE);
   localparam int BLK_W        = $clog2(NUM_BLOCKS);
   localparam int PTR_W        = POS_W + 1;
   localparam int LEN_W        = 11;
   localparam int DATA_W       = 32;

   localparam logic signed [DATA_W-1:0] INT_MAX      = 32'sh7FFF_FFFF;
   localparam logic [LEN_W-1:0]         LENGTH_RESET = 11'd1024;

   // Operation codes of an input item.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Result status codes.
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_RANGE = 1'b1;

   typedef struct packed {
      logic                     operation;
      logic [POS_W-1:0]         left_position;
      logic [POS_W-1:0]         right_position;
      logic signed [DATA_W-1:0] new_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] range_minimum;
      logic                     status;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic idle;
      logic load_item;
      logic clear_en;
      logic write_elem;
      logic start_scan;
      logic issue;
      logic write_bmin;
      logic load_rsp;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic item_is_query;
      logic write_ok;
      logic query_bad;
      logic scan_last;
      logic clear_last;
      logic rsp_busy;
   } dp_status_type;

endpackage

>>> hdl/brm_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the range minimum core.
module brm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  brm_pkg::dp_status_type dp_status,
   output brm_pkg::ctl_cmd_type   ctl_cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;
   localparam logic [2:0] ST_COMMIT = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      ctl_cmd  = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl_cmd.clear_en = 1'b1;
            if (dp_status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ctl_cmd.idle = 1'b1;
            if (req_valid) begin
               ctl_cmd.load_item = 1'b1;
               state_in          = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!dp_status.item_is_query) begin
               if (dp_status.write_ok) begin
                  ctl_cmd.write_elem = 1'b1;
                  ctl_cmd.start_scan = 1'b1;
                  state_in           = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (dp_status.query_bad) begin
               state_in = ST_FINISH;
            end else begin
               ctl_cmd.start_scan = 1'b1;
               state_in           = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl_cmd.issue = 1'b1;
            if (dp_status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = dp_status.item_is_query ? ST_FINISH : ST_COMMIT;
         end
         ST_COMMIT: begin
            ctl_cmd.write_bmin = 1'b1;
            state_in           = ST_IDLE;
         end
         ST_FINISH: begin
            if (!dp_status.rsp_busy) begin
               ctl_cmd.load_rsp = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/brm_dpath.sv
`timescale 1ns / 1ps
// Datapath of the range minimum core: element and block memories, scan and result.
module brm_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  brm_pkg::ctl_cmd_type              ctl_cmd,
   input  brm_pkg::req_payload_type          req_payload,
   input  logic                              csr_write_enable,
   input  logic [brm_pkg::LEN_W-1:0]         csr_write_data,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output brm_pkg::rsp_payload_type          rsp_payload,
   output brm_pkg::dp_status_type            dp_status
);

   logic signed [brm_pkg::DATA_W-1:0] elem_mem [brm_pkg::MAX_ELEMENTS];
   logic signed [brm_pkg::DATA_W-1:0] bmin_mem [brm_pkg::NUM_BLOCKS];

   brm_pkg::req_payload_type          item_ff;
   logic [brm_pkg::LEN_W-1:0]         length_ff;
   logic [brm_pkg::POS_W-1:0]         clr_ff;
   logic [brm_pkg::PTR_W-1:0]         ptr_ff;
   logic [brm_pkg::PTR_W-1:0]         ptr_in;
   logic signed [brm_pkg::DATA_W-1:0] acc_ff;
   logic signed [brm_pkg::DATA_W-1:0] elem_rd_ff;
   logic signed [brm_pkg::DATA_W-1:0] bmin_rd_ff;
   logic                              pend_ff;
   logic                              pend_blk_ff;
   logic                              rsp_valid_ff;
   brm_pkg::rsp_payload_type          rsp_ff;

   logic [brm_pkg::LEN_W-1:0]         len_eff;
   logic                              use_block;
   logic [brm_pkg::PTR_W:0]           block_end;
   logic signed [brm_pkg::DATA_W-1:0] cand;
   logic [brm_pkg::PTR_W-1:0]         ptr_start;
   logic [brm_pkg::POS_W-1:0]         elem_waddr;
   logic signed [brm_pkg::DATA_W-1:0] elem_wdata;
   logic [brm_pkg::BLK_W-1:0]         bmin_waddr;
   logic signed [brm_pkg::DATA_W-1:0] bmin_wdata;

   // Length in use, capped at the array size.
   assign len_eff = (length_ff > brm_pkg::LEN_W'(brm_pkg::MAX_ELEMENTS))
                  ? brm_pkg::LEN_W'(brm_pkg::MAX_ELEMENTS) : length_ff;

   // A query reads a stored block minimum when a whole block starts at the pointer.
   assign block_end = {1'b0, ptr_ff} + (brm_pkg::PTR_W + 1)'(brm_pkg::BLOCK_SIZE - 1);
   assign use_block = item_ff.operation == brm_pkg::OP_QUERY
                   && ptr_ff[brm_pkg::OFF_W-1:0] == '0
                   && block_end <= {2'b00, item_ff.right_position};
   assign ptr_in    = ptr_ff + (use_block ? brm_pkg::PTR_W'(brm_pkg::BLOCK_SIZE)
                                          : brm_pkg::PTR_W'(1));

   // A query starts at its left end; a rebuild starts at the head of the written block.
   assign ptr_start = (item_ff.operation == brm_pkg::OP_QUERY)
                    ? {1'b0, item_ff.left_position}
                    : {1'b0, item_ff.left_position[brm_pkg::POS_W-1:brm_pkg::OFF_W],
                       brm_pkg::OFF_W'(0)};

   // Status toward the controller.
   always_comb begin
      dp_status.item_is_query = item_ff.operation == brm_pkg::OP_QUERY;
      dp_status.write_ok      = {1'b0, item_ff.left_position} < len_eff;
      dp_status.query_bad     = item_ff.left_position > item_ff.right_position
                             || {1'b0, item_ff.right_position} >= len_eff;
      dp_status.scan_last     = (item_ff.operation == brm_pkg::OP_QUERY)
                             ? ptr_in > {1'b0, item_ff.right_position}
                             : ptr_ff[brm_pkg::OFF_W-1:0] == '1;
      dp_status.clear_last    = clr_ff == brm_pkg::POS_W'(brm_pkg::MAX_ELEMENTS - 1);
      dp_status.rsp_busy      = rsp_valid_ff && rsp_stall;
   end

   // Write ports: the clearing sweep writes zeros, otherwise the item and the block minimum.
   assign elem_waddr = ctl_cmd.clear_en ? clr_ff : item_ff.left_position;
   assign elem_wdata = ctl_cmd.clear_en ? '0 : item_ff.new_value;
   assign bmin_waddr = ctl_cmd.clear_en ? clr_ff[brm_pkg::POS_W-1:brm_pkg::OFF_W]
                                        : item_ff.left_position[brm_pkg::POS_W-1:brm_pkg::OFF_W];
   assign bmin_wdata = ctl_cmd.clear_en ? '0 : acc_ff;

   // Element memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (ctl_cmd.clear_en || ctl_cmd.write_elem) begin
         elem_mem[elem_waddr] <= elem_wdata;
      end
      elem_rd_ff <= elem_mem[ptr_ff[brm_pkg::POS_W-1:0]];
   end

   // Block minimum memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (ctl_cmd.clear_en || ctl_cmd.write_bmin) begin
         bmin_mem[bmin_waddr] <= bmin_wdata;
      end
      bmin_rd_ff <= bmin_mem[ptr_ff[brm_pkg::POS_W-1:brm_pkg::OFF_W]];
   end

   // Configuration register and clearing counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= brm_pkg::LENGTH_RESET;
         clr_ff    <= '0;
      end else begin
         if (csr_write_enable) begin
            length_ff <= csr_write_data;
         end
         if (ctl_cmd.clear_en) begin
            clr_ff <= clr_ff + brm_pkg::POS_W'(1);
         end
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (ctl_cmd.load_item) begin
         item_ff <= req_payload;
      end
   end

   // Read pointer and tags of the read in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= ctl_cmd.issue;
      end
      pend_blk_ff <= use_block;
      if (ctl_cmd.start_scan) begin
         ptr_ff <= ptr_start;
      end else if (ctl_cmd.issue) begin
         ptr_ff <= ptr_in;
      end
   end

   // Running minimum over returned reads.
   assign cand = pend_blk_ff ? bmin_rd_ff : elem_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl_cmd.start_scan) begin
         acc_ff <= brm_pkg::INT_MAX;
      end else if (pend_ff && cand < acc_ff) begin
         acc_ff <= cand;
      end
   end

   // Output register; it holds while the result is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl_cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctl_cmd.load_rsp) begin
         rsp_ff.status        <= dp_status.query_bad ? brm_pkg::STATUS_BAD_RANGE
                                                     : brm_pkg::STATUS_OK;
         rsp_ff.range_minimum <= dp_status.query_bad ? '0 : acc_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> hdl/block_range_minimum_core.sv
`timescale 1ns / 1ps
// Range minimum core over 1024 signed words kept in blocks of 32 with stored block minima.
// A query reads its partial elements plus whole blocks by their stored minima (up to 92 reads),
// one read per cycle through the element and block memory ports; a bad range skips the reads.
// A write is the store plus 32 reads that rebuild its block minimum.
// One item is worked at a time; a result waits in an output register while the next is taken.
// After synchronous reset a sweep zeroes the memories with req_stall held high.
`include "block_range_minimum_core_assert.svh"
module block_range_minimum_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  brm_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output brm_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [brm_pkg::LEN_W-1:0] csr_write_data
);

   brm_pkg::ctl_cmd_type   ctl_cmd;
   brm_pkg::dp_status_type dp_status;

   // Controller.
   brm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .dp_status (dp_status),
      .ctl_cmd   (ctl_cmd)
   );

   // Datapath.
   brm_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctl_cmd          (ctl_cmd),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .dp_status        (dp_status)
   );

   // Items are taken only while the controller is idle.
   assign req_stall = !ctl_cmd.idle;

   // An accepted item closes the input until its work is done.
   `BRM_ASSERT(a_accept_closes, clock, reset, (req_valid && !req_stall) |=> req_stall)
   // A new result is never loaded over one that is still stalled.
   `BRM_ASSERT_IMP(a_load_free, clock, reset, ctl_cmd.load_rsp, !(rsp_valid && rsp_stall))
   // Clearing, block minimum writes, scan reads and result loads never overlap.
   `BRM_ASSERT(a_cmd_excl, clock, reset,
      $onehot0({ctl_cmd.clear_en, ctl_cmd.write_bmin, ctl_cmd.issue, ctl_cmd.load_rsp}))
   // The clearing sweep holds the input closed after reset.
   `BRM_ASSERT_IMP(a_clear_stall, clock, reset, $fell(reset), req_stall)

endmodule

>>> bench/tb_block_range_minimum_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the block range minimum core: writes, range queries, length settings.
module tb_block_range_minimum_core;
   import brm_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES   = 400;
   localparam int NUM_PHASES    = 9;
   localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Length setting, item count and idle chances (percent) of each random phase.
   localparam int PHASE_LENGTH [NUM_PHASES] = '{1024, 1, 37, 2047, 0, 64, 513, 1000, 1024};
   localparam int PHASE_ITEMS  [NUM_PHASES] = '{240, 80, 200, 240, 40, 200, 240, 220, 200};
   localparam int REQ_IDLE     [NUM_PHASES] = '{20, 25, 0, 30, 10, 20, 0, 25, 0};
   localparam int RSP_IDLE     [NUM_PHASES] = '{6, 0, 8, 10, 5, 6, 12, 0, 0};

   typedef enum logic [1:0] {ROW_TYPED, ROW_PREDICTED, ROW_LENGTH} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      req_payload_type  item;
      rsp_payload_type  typed_result;
      logic [LEN_W-1:0] length_value;
   } directed_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_payload_type  req_payload;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_payload_type  rsp_payload;
   logic             csr_write_enable;
   logic [LEN_W-1:0] csr_write_data;

   // Shadow copy of the array, its block minima and the length setting.
   logic signed [DATA_W-1:0] stored_words [MAX_ELEMENTS];
   logic signed [DATA_W-1:0] word_block_min [NUM_BLOCKS];
   logic [LEN_W-1:0]         length_setting;

   rsp_payload_type  pending_minima [$];
   directed_row_type directed_rows [$];

   int          mismatch_count = 0;
   int          results_checked = 0;
   int          writes_sent = 0;
   int          queries_sent = 0;
   int          bad_ranges = 0;
   int          length_writes = 0;
   int          rsp_idle_pct = 0;
   bit          long_hold_wanted = 1'b0;
   int unsigned cycle_count = 0;

   block_range_minimum_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // 20 ns clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Positions at or beyond this count are out of range.
   function automatic int unsigned usable_length();
      return (length_setting < MAX_ELEMENTS) ? int'(length_setting) : MAX_ELEMENTS;
   endfunction

   // Store a word and rebuild the minimum of its whole block.
   function automatic void store_word(int unsigned pos, logic signed [DATA_W-1:0] value);
      int unsigned              base;
      logic signed [DATA_W-1:0] least;
      if (pos >= usable_length()) return;
      stored_words[pos] = value;
      base = (pos / BLOCK_SIZE) * BLOCK_SIZE;
      least = stored_words[base];
      for (int i = 1; i < BLOCK_SIZE; i++) begin
         if (stored_words[base + i] < least) least = stored_words[base + i];
      end
      word_block_min[pos / BLOCK_SIZE] = least;
   endfunction

   // Minimum over [left, right]: ragged ends word by word, whole blocks by their minima.
   function automatic rsp_payload_type range_minimum_of(int unsigned left, int unsigned right);
      rsp_payload_type          result;
      int unsigned              head;
      int unsigned              tail;
      logic signed [DATA_W-1:0] least;
      result.range_minimum = '0;
      result.status = STATUS_OK;
      if (left > right || right >= usable_length()) begin
         result.status = STATUS_BAD_RANGE;
         return result;
      end
      least = stored_words[left];
      head = left;
      tail = right + 1;
      while (head < tail && head % BLOCK_SIZE != 0) begin
         if (stored_words[head] < least) least = stored_words[head];
         head++;
      end
      while (tail > head && tail % BLOCK_SIZE != 0) begin
         tail--;
         if (stored_words[tail] < least) least = stored_words[tail];
      end
      for (int unsigned b = head; b < tail; b += BLOCK_SIZE) begin
         if (word_block_min[b / BLOCK_SIZE] < least) least = word_block_min[b / BLOCK_SIZE];
      end
      result.range_minimum = least;
      return result;
   endfunction

   // Values lean toward the extremes and toward small numbers that give ties.
   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0: return INT_MIN;
         1: return INT_MAX;
         2, 3: return $signed($urandom_range(0, 16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   // Mostly well-formed items inside the length in use, some anywhere in the field range.
   function automatic req_payload_type random_item(int unsigned len);
      req_payload_type item;
      int unsigned     left;
      int unsigned     right;
      int unsigned     pick;
      item.operation = ($urandom_range(0, 99) < 40) ? OP_WRITE : OP_QUERY;
      item.new_value = random_value();
      left = $urandom_range(0, MAX_ELEMENTS - 1);
      right = $urandom_range(0, MAX_ELEMENTS - 1);
      if (len != 0 && $urandom_range(0, 99) < 90) begin
         left = $urandom_range(0, len - 1);
         if (item.operation == OP_QUERY) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               right = left + $urandom_range(0, 3);
            end else if (pick < 50) begin
               left = (left / BLOCK_SIZE) * BLOCK_SIZE;
               right = left + BLOCK_SIZE * $urandom_range(1, 4) - 1;
            end else begin
               right = $urandom_range(left, len - 1);
            end
            if (right >= len) right = len - 1;
            // Right end one past the last word in use.
            if (pick >= 95 && len < MAX_ELEMENTS) right = len;
         end
      end
      item.left_position = left[POS_W-1:0];
      item.right_position = right[POS_W-1:0];
      return item;
   endfunction

   function automatic void add_item(row_kind_type kind, logic op, int unsigned left,
                                    int unsigned right, logic signed [DATA_W-1:0] value,
                                    logic signed [DATA_W-1:0] typed_min, logic typed_status);
      directed_row_type row;
      row.kind = kind;
      row.item.operation = op;
      row.item.left_position = left[POS_W-1:0];
      row.item.right_position = right[POS_W-1:0];
      row.item.new_value = value;
      row.typed_result.range_minimum = typed_min;
      row.typed_result.status = typed_status;
      row.length_value = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_length(logic [LEN_W-1:0] value);
      directed_row_type row;
      row.kind = ROW_LENGTH;
      row.item = '0;
      row.typed_result = '0;
      row.length_value = value;
      directed_rows.push_back(row);
   endfunction

   // Offer one item, update the shadow state when it is taken, then maybe go idle.
   task automatic drive_item(input req_payload_type item, input bit typed,
                             input rsp_payload_type typed_result, input int idle_pct);
      rsp_payload_type predicted;
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      if (item.operation == OP_QUERY) begin
         predicted = range_minimum_of(item.left_position, item.right_position);
         pending_minima.push_back(typed ? typed_result : predicted);
         queries_sent++;
         if (predicted.status == STATUS_BAD_RANGE) bad_ranges++;
      end else begin
         store_word(item.left_position, item.new_value);
         writes_sent++;
      end
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Stop offering and wait for every outstanding result.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_minima.size() != 0);
   endtask

   // Change the length only once the core has gone quiet; a trailing write has no result.
   task automatic set_length(input logic [LEN_W-1:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      length_setting = value;
      length_writes++;
   endtask

   // Receiver: random stall bursts, and one long hold-off on request.
   initial begin : rsp_side
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_wanted) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold_wanted = 1'b0;
         end else if (rsp_idle_pct != 0 && $urandom_range(1, 100) <= rsp_idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each taken result with the oldest expectation.
   always @(posedge clock) begin : result_check
      rsp_payload_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (pending_minima.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result: range_minimum %0d status %0b",
                        rsp_payload.range_minimum, rsp_payload.status);
         end else begin
            wanted = pending_minima.pop_front();
            if (rsp_payload.range_minimum !== wanted.range_minimum ||
                rsp_payload.status !== wanted.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch on result %0d: min exp %0d got %0d, status exp %0b got %0b",
                           results_checked, wanted.range_minimum, rsp_payload.range_minimum,
                           wanted.status, rsp_payload.status);
            end
         end
      end
   end

   // Guard against a hang.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_minima.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      int p;
      int n;
      for (int i = 0; i < MAX_ELEMENTS; i++) stored_words[i] = '0;
      for (int i = 0; i < NUM_BLOCKS; i++) word_block_min[i] = '0;
      length_setting = LENGTH_RESET;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= LENGTH_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Fresh store, extremes, a raised value, ragged and whole blocks, bad ranges.
      add_item(ROW_TYPED, OP_QUERY, 0, 1023, 0, 0, STATUS_OK);
      add_item(ROW_TYPED, OP_QUERY, 0, 0, 0, 0, STATUS_OK);
      add_item(ROW_TYPED, OP_QUERY, 5, 3, 0, 0, STATUS_BAD_RANGE);
      add_item(ROW_PREDICTED, OP_WRITE, 1023, 1023, INT_MIN, 0, STATUS_OK);
      add_item(ROW_TYPED, OP_QUERY, 0, 1023, 0, INT_MIN, STATUS_OK);
      add_item(ROW_PREDICTED, OP_WRITE, 0, 0, INT_MAX, 0, STATUS_OK);
      add_item(ROW_TYPED, OP_QUERY, 0, 0, 0, INT_MAX, STATUS_OK);
      add_item(ROW_TYPED, OP_QUERY, 1023, 1023, 0, INT_MIN, STATUS_OK);
      // Raising the only low word must lift its block minimum again.
      add_item(ROW_PREDICTED, OP_WRITE, 1023, 0, INT_MAX, 0, STATUS_OK);
      add_item(ROW_TYPED, OP_QUERY, 992, 1023, 0, 0, STATUS_OK);
      add_item(ROW_PREDICTED, OP_QUERY, 1, 1022, 0, 0, STATUS_OK);
      add_item(ROW_PREDICTED, OP_WRITE, 40, 1023, -5, 0, STATUS_OK);
      add_item(ROW_PREDICTED, OP_QUERY, 33, 63, 0, 0, STATUS_OK);
      add_item(ROW_PREDICTED, OP_QUERY, 32, 63, 0, 0, STATUS_OK);
      add_item(ROW_PREDICTED, OP_QUERY, 31, 64, 0, 0, STATUS_OK);
      add_item(ROW_PREDICTED, OP_QUERY, 0, 1023, -1, 0, STATUS_OK);
      add_item(ROW_TYPED, OP_QUERY, 1023, 0, 0, 0, STATUS_BAD_RANGE);
      // Short length: a write past the end is dropped and the end bounds queries.
      add_length(LEN_W'(10));
      add_item(ROW_PREDICTED, OP_WRITE, 10, 0, 99, 0, STATUS_OK);
      add_item(ROW_PREDICTED, OP_QUERY, 0, 9, 0, 0, STATUS_OK);
      add_item(ROW_TYPED, OP_QUERY, 0, 10, 0, 0, STATUS_BAD_RANGE);
      // Zero length: everything is out of range.
      add_length(LEN_W'(0));
      add_item(ROW_PREDICTED, OP_WRITE, 0, 0, -1, 0, STATUS_OK);
      add_item(ROW_TYPED, OP_QUERY, 0, 0, 0, 0, STATUS_BAD_RANGE);
      // A length above the array size acts as the full array.
      add_length(11'd2047);
      add_item(ROW_PREDICTED, OP_QUERY, 0, 1023, 0, 0, STATUS_OK);
      add_item(ROW_TYPED, OP_QUERY, 0, 0, 0, INT_MAX, STATUS_OK);

      rsp_idle_pct = 8;
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_LENGTH)
            set_length(directed_rows[r].length_value);
         else
            drive_item(directed_rows[r].item, directed_rows[r].kind == ROW_TYPED,
                       directed_rows[r].typed_result, 0);
      end

      // Random phases, one length setting each; the last runs with no idling.
      for (p = 0; p < NUM_PHASES; p++) begin
         set_length(PHASE_LENGTH[p][LEN_W-1:0]);
         rsp_idle_pct = RSP_IDLE[p];
         for (n = 0; n < PHASE_ITEMS[p]; n++) begin
            if (p == 0 && n == 60) long_hold_wanted = 1'b1;
            if (p == 2 && n == 100) drain_results();
            drive_item(random_item(usable_length()), 1'b0, '0, REQ_IDLE[p]);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d writes and %0d queries (%0d bad ranges) over %0d length settings.",
               writes_sent, queries_sent, bad_ranges, length_writes);
      $display("Checked %0d results through a long receiver hold-off and a full drain pause.",
               results_checked);
      if (mismatch_count == 0 && pending_minima.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
